/* hdl/tcp_ct_pkg.sv */
// Package for the TCP connection tracking table: sizes, TCP state codes,
// service ports and the records that pass between the controller and the cells.
// No dependencies.
package tcp_ct_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int STALE_FACTOR  = 10;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int SF_W          = $clog2(STALE_FACTOR + 1);
	localparam int TS_W          = 16 + SF_W;

	localparam logic [1:0] CMD_SYN   = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_FTP   = 2'd2;
	localparam logic [1:0] CMD_BAD   = 2'd3;

	localparam logic [3:0] ST_CLOSED       = 4'd0;
	localparam logic [3:0] ST_LISTEN       = 4'd1;
	localparam logic [3:0] ST_SYN_SENT     = 4'd2;
	localparam logic [3:0] ST_SYN_RECEIVED = 4'd3;
	localparam logic [3:0] ST_ESTABLISHED  = 4'd4;
	localparam logic [3:0] ST_FIN_WAIT_1   = 4'd5;
	localparam logic [3:0] ST_FIN_WAIT_2   = 4'd6;
	localparam logic [3:0] ST_CLOSE_WAIT   = 4'd7;
	localparam logic [3:0] ST_LAST_ACK     = 4'd8;
	localparam logic [3:0] ST_TIME_WAIT    = 4'd9;
	localparam logic [3:0] ST_FTP_DATA     = 4'd10;

	localparam logic [15:0] FTP_DATA_PORT = 16'd20;
	localparam logic [15:0] HTTP_PORT     = 16'd80;
	localparam logic [15:0] FTP_CTRL_PORT = 16'd21;
	localparam logic [15:0] SMTP_PORT     = 16'd25;

	localparam logic [2:0] RSN_NO_CONN  = 3'd0;
	localparam logic [2:0] RSN_EXISTS   = 3'd1;
	localparam logic [2:0] RSN_NONCOMP  = 3'd2;
	localparam logic [2:0] RSN_BLOCKED  = 3'd3;
	localparam logic [2:0] RSN_ADDED    = 3'd4;
	localparam logic [2:0] RSN_DUP      = 3'd5;
	localparam logic [2:0] RSN_FULL     = 3'd6;

	// lookup key broadcast to every cell
	typedef struct packed {
		logic [31:0] sip;
		logic [15:0] sp;
		logic [31:0] dip;
		logic [15:0] dp;
	} key_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic            active;
		logic            found;
		logic [IDX_W-1:0] idx;
		logic [31:0]     cip;
		logic [15:0]     cport;
		logic [31:0]     sip;
		logic [15:0]     sport;
		logic [3:0]      cs;
		logic [3:0]      ss;
		logic [2:0]      hook;
		logic            free_found;
		logic [IDX_W-1:0] free_idx;
	} chain_t;

	// write-back broadcast
	typedef struct packed {
		logic            en;
		logic            add;
		logic [IDX_W-1:0] idx;
		logic [31:0]     cip;
		logic [15:0]     cport;
		logic [31:0]     sip;
		logic [15:0]     sport;
		logic [3:0]      cs;
		logic [3:0]      ss;
		logic [31:0]     stamp;
		logic [2:0]      hook;
	} wr_t;

	// aging command
	typedef struct packed {
		logic        en;
		logic [31:0] expiry;
		logic [31:0] stale;
	} age_t;

endpackage

/* hdl/tcp_ct_if.sv */
// Stream channels of the TCP connection tracking table: packet beats in,
// verdict beats out. Depends on nothing.
interface tcp_ct_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] src_ip;
	logic [15:0] src_tcp_port;
	logic [31:0] dst_ip;
	logic [15:0] dst_tcp_port;
	logic        syn_flag;
	logic        fin_flag;
	logic [2:0]  hook_id;
	logic [31:0] now_seconds;
	logic        content_drop;
	modport source (output valid, cmd, src_ip, src_tcp_port, dst_ip, dst_tcp_port, syn_flag,
		fin_flag, hook_id, now_seconds, content_drop, input ready);
	modport sink (input valid, cmd, src_ip, src_tcp_port, dst_ip, dst_tcp_port, syn_flag,
		fin_flag, hook_id, now_seconds, content_drop, output ready);
endinterface

interface tcp_ct_out_if;
	logic       valid;
	logic       ready;
	logic       drop;
	logic [2:0] reason;
	modport source (output valid, drop, reason, input ready);
	modport sink (input valid, drop, reason, output ready);
endinterface

/* hdl/tcp_ct_cell.sv */
// One table entry of the connection tracking chain: holds the entry, ages it,
// updates the passing scan token and takes write-backs. Depends on tcp_ct_pkg.
module tcp_ct_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [tcp_ct_pkg::IDX_W-1:0] my_idx,
	input  tcp_ct_pkg::age_t         age,
	input  tcp_ct_pkg::key_t         key,
	input  tcp_ct_pkg::wr_t          wr,
	input  tcp_ct_pkg::chain_t       chain_in,
	output tcp_ct_pkg::chain_t       chain_out
);
	import tcp_ct_pkg::*;

	logic        valid_q;
	logic [31:0] cip_q;
	logic [15:0] cport_q;
	logic [31:0] sip_q;
	logic [15:0] sport_q;
	logic [3:0]  cs_q;
	logic [3:0]  ss_q;
	logic [31:0] stamp_q;
	logic [2:0]  hook_q;
	logic        expire;
	logic        match;
	logic        wr_hit;
	chain_t      nxt;

	assign expire = ((cs_q == ST_SYN_SENT || cs_q == ST_FTP_DATA) && stamp_q < age.expiry)
		|| cs_q == ST_CLOSED || ss_q == ST_CLOSED || stamp_q < age.stale;
	assign match = (cip_q == key.sip && cport_q == key.sp && sip_q == key.dip
		&& sport_q == key.dp) || (cip_q == key.dip && cport_q == key.dp
		&& sip_q == key.sip && sport_q == key.sp);
	assign wr_hit = wr.en && wr.idx == my_idx;

	always_comb begin
		nxt = chain_in;
		if (chain_in.active) begin
			if (valid_q && !chain_in.found && match) begin
				nxt.found = 1'b1;
				nxt.idx   = my_idx;
				nxt.cip   = cip_q;
				nxt.cport = cport_q;
				nxt.sip   = sip_q;
				nxt.sport = sport_q;
				nxt.cs    = cs_q;
				nxt.ss    = ss_q;
				nxt.hook  = hook_q;
			end
			if (!valid_q && !chain_in.free_found) begin
				nxt.free_found = 1'b1;
				nxt.free_idx   = my_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			chain_out <= '0;
		end else begin
			chain_out <= nxt;
			if (age.en && valid_q && expire) begin
				valid_q <= 1'b0;
			end else if (wr_hit && wr.add) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			cs_q    <= wr.cs;
			ss_q    <= wr.ss;
			stamp_q <= wr.stamp;
			if (wr.add) begin
				cip_q   <= wr.cip;
				cport_q <= wr.cport;
				sip_q   <= wr.sip;
				sport_q <= wr.sport;
				hook_q  <= wr.hook;
			end
		end
	end

endmodule

/* hdl/tcp_connection_tracking_table_top.sv */
// Top level of the TCP connection tracking table: APB timeout register,
// sequencer, chain of entry cells and verdict register. Depends on tcp_ct_pkg,
// tcp_ct_if and tcp_ct_cell.
//
//  channel  direction  beat
//  in_ch    sink       cmd, 4-tuple, flags, hook, time, content verdict
//  out_ch   source     drop, reason
//  apb      slave      handshake_timeout at byte address 0
//
// A packet passes from one accepted beat to the next through an aging step, a
// launch step, the scan token stepping one cell per cycle down the chain (the
// last step captures the result), a done step that writes back and registers
// the verdict, and the idle state that takes the next beat. Command 3 goes
// from idle straight to the done step. Reset clears every entry valid bit at
// once, no clearing pass. The verdict register lets the next packet in while a
// verdict waits; write-back stalls only while it is full.
module tcp_connection_tracking_table_top (
	input  logic        clk,
	input  logic        arst_n,
	tcp_ct_in_if.sink   in_ch,
	tcp_ct_out_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tcp_ct_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_AGE, S_LAUNCH, S_SCAN, S_DONE} state_t;

	state_t      state_q;
	logic [15:0] timeout_q;
	logic [1:0]  cmd_q;
	key_t        key_q;
	logic [15:0] dport_q;
	logic        syn_q;
	logic        fin_q;
	logic [2:0]  hook_q;
	logic [31:0] now_q;
	logic        cdrop_q;
	logic [31:0] expiry_q;
	logic [31:0] stale_q;
	chain_t      res_q;
	logic        out_valid_q;
	logic        out_drop_q;
	logic [2:0]  out_reason_q;

	chain_t      chain [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] act_bits;
	age_t        age;
	key_t        key;
	wr_t         wr;
	logic        accept;
	logic        finish;
	logic [TS_W-1:0] ts;
	logic [32:0] exp_diff;
	logic [32:0] stale_diff;
	logic        r_drop;
	logic [2:0]  r_reason;
	logic        rev;
	logic [3:0]  ncs;
	logic [3:0]  nss;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, timeout_q};

	assign in_ch.ready = state_q == S_IDLE;
	assign accept = in_ch.valid && in_ch.ready;
	assign finish = state_q == S_DONE && (!out_valid_q || out_ch.ready);

	assign out_ch.valid  = out_valid_q;
	assign out_ch.drop   = out_drop_q;
	assign out_ch.reason = out_reason_q;

	// saturating thresholds for aging
	assign ts = TS_W'(timeout_q) * TS_W'(STALE_FACTOR);
	assign exp_diff = {1'b0, in_ch.now_seconds} - 33'(timeout_q);
	assign stale_diff = {1'b0, in_ch.now_seconds} - 33'(ts);

	assign age.en = state_q == S_AGE;
	assign age.expiry = expiry_q;
	assign age.stale = stale_q;

	always_comb begin
		key = key_q;
		key.dp = dport_q;
	end

	always_comb begin
		chain[0] = '0;
		chain[0].active = state_q == S_LAUNCH;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		tcp_ct_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.my_idx(IDX_W'(i)),
			.age(age),
			.key(key),
			.wr(wr),
			.chain_in(chain[i]),
			.chain_out(chain[i+1])
		);
		assign act_bits[i] = chain[i+1].active;
	end

	// verdict and write-back from the captured scan result
	always_comb begin
		r_drop = 1'b0;
		r_reason = RSN_EXISTS;
		wr = '0;
		wr.idx = res_q.idx;
		wr.cip = key_q.sip;
		wr.cport = key_q.sp;
		wr.sip = key_q.dip;
		wr.sport = dport_q;
		wr.stamp = now_q;
		wr.hook = hook_q;
		rev = key_q.sip == res_q.sip && key_q.sp == res_q.sport
			&& key_q.dip == res_q.cip && key_q.dp == res_q.cport;
		ncs = res_q.cs;
		nss = res_q.ss;
		unique case (cmd_q)
			CMD_BAD: begin
				r_drop = 1'b1;
				r_reason = RSN_NONCOMP;
			end
			CMD_SYN, CMD_FTP: begin
				if (res_q.found) begin
					r_reason = RSN_DUP;
				end else if (!res_q.free_found) begin
					r_drop = cmd_q == CMD_FTP;
					r_reason = RSN_FULL;
				end else begin
					r_reason = RSN_ADDED;
					wr.en = 1'b1;
					wr.add = 1'b1;
					wr.idx = res_q.free_idx;
					ncs = (cmd_q == CMD_FTP) ? ST_FTP_DATA : ST_SYN_SENT;
					nss = (cmd_q == CMD_FTP) ? ST_FTP_DATA : ST_LISTEN;
				end
			end
			default: begin
				if (!res_q.found) begin
					r_drop = 1'b1;
					r_reason = RSN_NO_CONN;
				end else if (res_q.cs != ST_FTP_DATA && res_q.hook != hook_q) begin
					r_reason = RSN_EXISTS;
				end else begin
					wr.en = 1'b1;
					if (res_q.cs == ST_SYN_SENT && rev && res_q.ss == ST_LISTEN && syn_q) begin
						nss = ST_SYN_RECEIVED;
					end else if (res_q.cs == ST_SYN_SENT && !rev
						&& res_q.ss == ST_SYN_RECEIVED && !syn_q) begin
						ncs = ST_ESTABLISHED;
						nss = ST_ESTABLISHED;
					end else if (res_q.cs != ST_FTP_DATA && syn_q) begin
						r_drop = 1'b1;
						r_reason = RSN_NONCOMP;
					end else if (res_q.cs == ST_ESTABLISHED || res_q.cs == ST_FTP_DATA) begin
						if (fin_q) begin
							ncs = rev ? ST_CLOSE_WAIT : ST_FIN_WAIT_1;
							nss = rev ? ST_FIN_WAIT_1 : ST_CLOSE_WAIT;
						end else if ((key_q.dp == HTTP_PORT || key_q.dp == FTP_CTRL_PORT
							|| key_q.dp == SMTP_PORT) && cdrop_q) begin
							ncs = ST_CLOSED;
							nss = ST_CLOSED;
							r_drop = 1'b1;
							r_reason = RSN_BLOCKED;
						end
					end else if (rev) begin
						if (res_q.cs == ST_FIN_WAIT_1 || res_q.cs == ST_FIN_WAIT_2) begin
							if (fin_q) begin
								ncs = ST_TIME_WAIT;
								nss = ST_LAST_ACK;
							end else if (res_q.cs == ST_FIN_WAIT_1) begin
								ncs = ST_FIN_WAIT_2;
							end
						end else if (res_q.cs == ST_LAST_ACK) begin
							ncs = ST_CLOSED;
						end
					end else begin
						if (res_q.ss == ST_FIN_WAIT_1 || res_q.ss == ST_FIN_WAIT_2) begin
							if (fin_q) begin
								nss = ST_TIME_WAIT;
								ncs = ST_LAST_ACK;
							end else if (res_q.ss == ST_FIN_WAIT_1) begin
								nss = ST_FIN_WAIT_2;
							end
						end else if (res_q.ss == ST_LAST_ACK) begin
							nss = ST_CLOSED;
						end
					end
				end
			end
		endcase
		wr.cs = ncs;
		wr.ss = nss;
		if (!finish) begin
			wr.en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			timeout_q <= 16'd60;
			out_valid_q <= 1'b0;
			out_drop_q <= 1'b0;
			out_reason_q <= RSN_NO_CONN;
		end else begin
			if (psel && penable && pwrite && !paddr[2]) begin
				timeout_q <= pwdata[15:0];
			end
			if (out_valid_q && out_ch.ready && !finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (in_ch.cmd == CMD_BAD) ? S_DONE : S_AGE;
					end
				end
				S_AGE: state_q <= S_LAUNCH;
				S_LAUNCH: state_q <= S_SCAN;
				S_SCAN: begin
					if (chain[TABLE_ENTRIES].active) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (finish) begin
						out_valid_q <= 1'b1;
						out_drop_q <= r_drop;
						out_reason_q <= r_reason;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_ch.cmd;
			key_q.sip <= in_ch.src_ip;
			key_q.sp <= in_ch.src_tcp_port;
			key_q.dip <= in_ch.dst_ip;
			key_q.dp <= in_ch.dst_tcp_port;
			dport_q <= (in_ch.cmd == CMD_FTP) ? FTP_DATA_PORT : in_ch.dst_tcp_port;
			syn_q <= in_ch.syn_flag;
			fin_q <= in_ch.fin_flag;
			hook_q <= in_ch.hook_id;
			now_q <= in_ch.now_seconds;
			cdrop_q <= in_ch.content_drop;
			expiry_q <= exp_diff[32] ? 32'd0 : exp_diff[31:0];
			stale_q <= stale_diff[32] ? 32'd0 : stale_diff[31:0];
			res_q <= '0;
		end else if (state_q == S_SCAN && chain[TABLE_ENTRIES].active) begin
			res_q <= chain[TABLE_ENTRIES];
		end
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_bits))
		else $error("more than one scan token in the chain");
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain[TABLE_ENTRIES].active |-> state_q == S_SCAN)
		else $error("scan token left the chain outside the scan");
	a_wr_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> state_q == S_DONE && finish)
		else $error("write-back outside the done step");
	a_hold_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_reason_q))
		else $error("stalled verdict lost");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for tcp_connection_tracking_table_top: drives packet beats and APB
// timeout writes, predicts every verdict in a scoreboard class and checks it.
// Depends on tcp_ct_pkg, tcp_ct_if and the top level of the block.
module tb_top;
	import tcp_ct_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 250;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] src_ip;
		logic [15:0] src_tcp_port;
		logic [31:0] dst_ip;
		logic [15:0] dst_tcp_port;
		logic        syn_flag;
		logic        fin_flag;
		logic [2:0]  hook_id;
		logic [31:0] now_seconds;
		logic        content_drop;
	} packet_t;

	typedef struct packed {
		logic       drop;
		logic [2:0] reason;
	} verdict_t;

	class conn_table_sb;
		logic [15:0] timeout;
		bit          vld[TABLE_ENTRIES];
		logic [31:0] cip[TABLE_ENTRIES];
		logic [15:0] cport[TABLE_ENTRIES];
		logic [31:0] sip[TABLE_ENTRIES];
		logic [15:0] sport[TABLE_ENTRIES];
		logic [3:0]  cst[TABLE_ENTRIES];
		logic [3:0]  sst[TABLE_ENTRIES];
		logic [31:0] stamp[TABLE_ENTRIES];
		logic [2:0]  hook[TABLE_ENTRIES];
		verdict_t    verdicts_due[$];
		int          errors;
		int          accepted;

		function new();
			timeout = 16'd60;
			errors = 0;
			accepted = 0;
			for (int i = 0; i < TABLE_ENTRIES; i++) vld[IDX_W'(i)] = 1'b0;
		endfunction

		function void age(logic [31:0] now);
			longint unsigned t, ts;
			logic [31:0] expiry, stale;
			logic [IDX_W-1:0] k;
			t = timeout;
			ts = t * STALE_FACTOR;
			expiry = (now > t) ? now - t[31:0] : 32'd0;
			stale = (now > ts) ? now - ts[31:0] : 32'd0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				k = IDX_W'(i);
				if (vld[k] && (((cst[k] == ST_SYN_SENT || cst[k] == ST_FTP_DATA)
						&& stamp[k] < expiry) || cst[k] == ST_CLOSED
						|| sst[k] == ST_CLOSED || stamp[k] < stale))
					vld[k] = 1'b0;
			end
		endfunction

		function int find(logic [31:0] a, logic [15:0] ap, logic [31:0] b, logic [15:0] bp);
			logic [IDX_W-1:0] k;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				k = IDX_W'(i);
				if (vld[k] && ((cip[k] == a && cport[k] == ap && sip[k] == b && sport[k] == bp)
						|| (cip[k] == b && cport[k] == bp && sip[k] == a && sport[k] == ap)))
					return i;
			end
			return -1;
		endfunction

		function verdict_t predict(packet_t p);
			verdict_t v;
			int idx;
			int slot;
			logic [IDX_W-1:0] e;
			bit rev;
			logic [15:0] srv_port;
			logic [3:0] cs, ss;
			v.drop = 1'b1;
			v.reason = RSN_NONCOMP;
			if (p.cmd == CMD_BAD)
				return v;
			age(p.now_seconds);
			v.drop = 1'b0;
			if (p.cmd != CMD_ACK) begin
				srv_port = (p.cmd == CMD_FTP) ? FTP_DATA_PORT : p.dst_tcp_port;
				if (find(p.src_ip, p.src_tcp_port, p.dst_ip, srv_port) >= 0) begin
					v.reason = RSN_DUP;
					return v;
				end
				slot = -1;
				for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
					if (!vld[IDX_W'(i)]) slot = i;
				if (slot < 0) begin
					v.drop = (p.cmd == CMD_FTP);
					v.reason = RSN_FULL;
					return v;
				end
				e = IDX_W'(slot);
				vld[e] = 1'b1;
				cip[e] = p.src_ip;
				cport[e] = p.src_tcp_port;
				sip[e] = p.dst_ip;
				sport[e] = srv_port;
				cst[e] = (p.cmd == CMD_FTP) ? ST_FTP_DATA : ST_SYN_SENT;
				sst[e] = (p.cmd == CMD_FTP) ? ST_FTP_DATA : ST_LISTEN;
				stamp[e] = p.now_seconds;
				hook[e] = p.hook_id;
				v.reason = RSN_ADDED;
				return v;
			end
			idx = find(p.src_ip, p.src_tcp_port, p.dst_ip, p.dst_tcp_port);
			if (idx < 0) begin
				v.drop = 1'b1;
				v.reason = RSN_NO_CONN;
				return v;
			end
			e = IDX_W'(idx);
			v.reason = RSN_EXISTS;
			// a packet seen at another hook passes untouched, unless the entry is FTP data
			if (cst[e] != ST_FTP_DATA && hook[e] != p.hook_id)
				return v;
			stamp[e] = p.now_seconds;
			rev = (p.src_ip == sip[e] && p.src_tcp_port == sport[e]
				&& p.dst_ip == cip[e] && p.dst_tcp_port == cport[e]);
			cs = cst[e];
			ss = sst[e];
			if (cs == ST_SYN_SENT) begin
				if (rev && ss == ST_LISTEN && p.syn_flag) begin
					sst[e] = ST_SYN_RECEIVED;
					return v;
				end
				if (!rev && ss == ST_SYN_RECEIVED && !p.syn_flag) begin
					cst[e] = ST_ESTABLISHED;
					sst[e] = ST_ESTABLISHED;
					return v;
				end
			end
			if (cs != ST_FTP_DATA && p.syn_flag) begin
				v.drop = 1'b1;
				v.reason = RSN_NONCOMP;
				return v;
			end
			if (cs == ST_ESTABLISHED || cs == ST_FTP_DATA) begin
				if (p.fin_flag) begin
					cst[e] = rev ? ST_CLOSE_WAIT : ST_FIN_WAIT_1;
					sst[e] = rev ? ST_FIN_WAIT_1 : ST_CLOSE_WAIT;
				end else if ((p.dst_tcp_port == HTTP_PORT || p.dst_tcp_port == FTP_CTRL_PORT
						|| p.dst_tcp_port == SMTP_PORT) && p.content_drop) begin
					cst[e] = ST_CLOSED;
					sst[e] = ST_CLOSED;
					v.drop = 1'b1;
					v.reason = RSN_BLOCKED;
				end
				return v;
			end
			if (rev) begin
				if (cs == ST_FIN_WAIT_1 || cs == ST_FIN_WAIT_2) begin
					if (p.fin_flag) begin
						cst[e] = ST_TIME_WAIT;
						sst[e] = ST_LAST_ACK;
					end else if (cs == ST_FIN_WAIT_1) begin
						cst[e] = ST_FIN_WAIT_2;
					end
				end else if (cs == ST_LAST_ACK) begin
					cst[e] = ST_CLOSED;
				end
			end else begin
				if (ss == ST_FIN_WAIT_1 || ss == ST_FIN_WAIT_2) begin
					if (p.fin_flag) begin
						sst[e] = ST_TIME_WAIT;
						cst[e] = ST_LAST_ACK;
					end else if (ss == ST_FIN_WAIT_1) begin
						sst[e] = ST_FIN_WAIT_2;
					end
				end else if (ss == ST_LAST_ACK) begin
					sst[e] = ST_CLOSED;
				end
			end
			return v;
		endfunction

		function void note_packet(packet_t p);
			verdicts_due.push_back(predict(p));
			accepted++;
		endfunction

		function void check_verdict(logic drop, logic [2:0] reason);
			verdict_t e;
			if (verdicts_due.size() == 0) begin
				$error("verdict with none outstanding: drop %0d reason %0d", drop, reason);
				errors++;
				return;
			end
			e = verdicts_due.pop_front();
			if (drop !== e.drop) begin
				$error("drop: expected %0d, got %0d", e.drop, drop);
				errors++;
			end
			if (reason !== e.reason) begin
				$error("reason: expected %0d, got %0d", e.reason, reason);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tcp_ct_in_if  in_ch();
	tcp_ct_out_if out_ch();

	tcp_connection_tracking_table_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	conn_table_sb tracker = new();

	int          tx_mode;
	int          rx_mode;
	bit          pressure_on;
	int          hold_cnt;
	int          quiet;
	logic [31:0] now;
	logic [31:0] ip_pool[4];
	logic [15:0] port_pool[4];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: optional long hold-off, else random stalls by mode
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cnt <= 0;
		end else if (pressure_on && hold_cnt < HOLD_CYCLES) begin
			out_ch.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			out_ch.ready <= !((rx_mode == 2 && $urandom_range(99) < 52)
				|| (rx_mode == 3 && $urandom_range(99) < 9));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			tracker.check_verdict(out_ch.drop, out_ch.reason);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic send_pkt(packet_t p);
		int pct;
		in_ch.valid <= 1'b1;
		in_ch.cmd <= p.cmd;
		in_ch.src_ip <= p.src_ip;
		in_ch.src_tcp_port <= p.src_tcp_port;
		in_ch.dst_ip <= p.dst_ip;
		in_ch.dst_tcp_port <= p.dst_tcp_port;
		in_ch.syn_flag <= p.syn_flag;
		in_ch.fin_flag <= p.fin_flag;
		in_ch.hook_id <= p.hook_id;
		in_ch.now_seconds <= p.now_seconds;
		in_ch.content_drop <= p.content_drop;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		tracker.note_packet(p);
		pct = (tx_mode == 1) ? 52 : (tx_mode == 3) ? 9 : 0;
		if ($urandom_range(99) < pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(99) < 90 ? $urandom_range(1, 5) : $urandom_range(6, 80))
				@(posedge clk);
		end
	endtask

	// time mostly creeps forward; now and then it leaps past the timeouts
	task automatic tick();
		longint unsigned span;
		span = longint'(tracker.timeout) * 12;
		if ($urandom_range(99) < 3)
			now = now + 32'($urandom_range(0, 32'(span)));
		else
			now = now + $urandom_range(0, 3);
	endtask

	task automatic pkt(logic [1:0] cmd, logic [31:0] a, logic [15:0] ap, logic [31:0] b,
			logic [15:0] bp, bit syn, bit fin, logic [2:0] hk, bit cdrop);
		packet_t p;
		tick();
		p.cmd = cmd;
		p.src_ip = a;
		p.src_tcp_port = ap;
		p.dst_ip = b;
		p.dst_tcp_port = bp;
		p.syn_flag = syn;
		p.fin_flag = fin;
		p.hook_id = hk;
		p.now_seconds = now;
		p.content_drop = cdrop;
		send_pkt(p);
	endtask

	function automatic logic [31:0] pick_ip();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return ip_pool[2'($urandom_range(3))];
		endcase
	endfunction

	function automatic logic [15:0] pick_srv_port();
		case ($urandom_range(7))
			0: return HTTP_PORT;
			1: return FTP_CTRL_PORT;
			2: return SMTP_PORT;
			3: return FTP_DATA_PORT;
			4: return 16'h0;
			5: return 16'hFFFF;
			default: return port_pool[2'($urandom_range(3))];
		endcase
	endfunction

	function automatic logic [15:0] pick_cli_port();
		return ($urandom_range(4) == 0) ? pick_srv_port() : port_pool[2'($urandom_range(3))];
	endfunction

	function automatic bit maybe(int pct);
		return $urandom_range(99) < pct;
	endfunction

	task automatic noise();
		pkt(2'($urandom_range(3)), $urandom, 16'($urandom), $urandom, 16'($urandom),
			1'($urandom), 1'($urandom), 3'($urandom), 1'($urandom));
	endtask

	// full life of one connection, with the odd wrong flag, hook or skipped beat
	task automatic run_conn();
		logic [31:0] c, s;
		logic [15:0] cp, sp;
		logic [2:0] hk;
		bit side;
		c = pick_ip();
		s = pick_ip();
		cp = pick_cli_port();
		sp = pick_srv_port();
		hk = 3'($urandom);
		pkt(CMD_SYN, c, cp, s, sp, 1'b1, maybe(5), hk, 1'($urandom));
		if (!maybe(8))
			pkt(CMD_ACK, s, sp, c, cp, !maybe(8), maybe(5), maybe(8) ? 3'($urandom) : hk,
				1'($urandom));
		if (!maybe(8))
			pkt(CMD_ACK, c, cp, s, sp, maybe(8), maybe(5), maybe(8) ? 3'($urandom) : hk,
				1'($urandom));
		repeat ($urandom_range(0, 4)) begin
			if (maybe(50))
				pkt(CMD_ACK, c, cp, s, sp, maybe(5), 1'b0, hk, maybe(15));
			else
				pkt(CMD_ACK, s, sp, c, cp, maybe(5), 1'b0, hk, maybe(15));
		end
		side = 1'($urandom);
		repeat ($urandom_range(2, 5)) begin
			if (side)
				pkt(CMD_ACK, c, cp, s, sp, maybe(4), maybe(60), maybe(5) ? 3'($urandom) : hk,
					maybe(10));
			else
				pkt(CMD_ACK, s, sp, c, cp, maybe(4), maybe(60), maybe(5) ? 3'($urandom) : hk,
					maybe(10));
			if (!maybe(20)) side = !side;
		end
	endtask

	task automatic run_ftp();
		logic [31:0] c, s;
		logic [15:0] cp;
		c = pick_ip();
		s = pick_ip();
		cp = pick_cli_port();
		pkt(CMD_FTP, c, cp, s, 16'($urandom), 1'b0, 1'b0, 3'($urandom), 1'($urandom));
		repeat ($urandom_range(1, 4)) begin
			if (maybe(50))
				pkt(CMD_ACK, s, FTP_DATA_PORT, c, cp, maybe(20), maybe(20), 3'($urandom),
					maybe(20));
			else
				pkt(CMD_ACK, c, cp, s, FTP_DATA_PORT, maybe(20), maybe(20), 3'($urandom),
					maybe(20));
		end
	endtask

	// drain outstanding verdicts before touching the register
	task automatic set_timeout(logic [15:0] val);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.verdicts_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {16'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.timeout = val;
	endtask

	initial begin
		logic [15:0] timeouts[8];
		int phase_start;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'd0;
		in_ch.valid <= 1'b0;
		in_ch.cmd <= CMD_SYN;
		in_ch.src_ip <= 32'd0;
		in_ch.src_tcp_port <= 16'd0;
		in_ch.dst_ip <= 32'd0;
		in_ch.dst_tcp_port <= 16'd0;
		in_ch.syn_flag <= 1'b0;
		in_ch.fin_flag <= 1'b0;
		in_ch.hook_id <= 3'd0;
		in_ch.now_seconds <= 32'd0;
		in_ch.content_drop <= 1'b0;
		tx_mode = 0;
		rx_mode = 0;
		pressure_on = 1'b0;
		quiet = 0;
		now = 32'd0;
		for (int i = 0; i < 4; i++) begin
			ip_pool[2'(i)] = $urandom;
			port_pool[2'(i)] = 16'($urandom);
		end
		timeouts = '{16'd60, 16'd1, 16'd65535, 16'($urandom_range(2, 500)), 16'd5,
			16'd65535, 16'($urandom_range(1, 65535)), 16'd60};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad command, unknown packet, extremes, duplicates both ways
		pkt(CMD_BAD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 3'd7, 1'b1);
		pkt(CMD_ACK, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0, 1'b0, 3'd0, 1'b0);
		pkt(CMD_SYN, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 3'd0, 1'b0);
		pkt(CMD_SYN, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 3'd0, 1'b0);
		pkt(CMD_SYN, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 1'b1, 1'b0, 3'd0, 1'b0);
		pkt(CMD_ACK, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 1'b1, 1'b0, 3'd5, 1'b0);
		pkt(CMD_ACK, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 1'b1, 1'b0, 3'd0, 1'b0);
		pkt(CMD_ACK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 3'd0, 1'b0);
		pkt(CMD_ACK, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 3'd0, 1'b0);
		pkt(CMD_SYN, 32'h0A00_0001, 16'd4000, 32'h0A00_0002, HTTP_PORT, 1'b1, 1'b0, 3'd2, 1'b0);
		pkt(CMD_ACK, 32'h0A00_0002, HTTP_PORT, 32'h0A00_0001, 16'd4000, 1'b1, 1'b0, 3'd2, 1'b0);
		pkt(CMD_ACK, 32'h0A00_0001, 16'd4000, 32'h0A00_0002, HTTP_PORT, 1'b0, 1'b0, 3'd2, 1'b0);
		pkt(CMD_ACK, 32'h0A00_0001, 16'd4000, 32'h0A00_0002, HTTP_PORT, 1'b0, 1'b0, 3'd2, 1'b1);
		pkt(CMD_ACK, 32'h0A00_0001, 16'd4000, 32'h0A00_0002, HTTP_PORT, 1'b0, 1'b0, 3'd2, 1'b0);
		pkt(CMD_FTP, 32'h0A00_0001, 16'd5000, 32'h0A00_0002, 16'hFFFF, 1'b0, 1'b0, 3'd1, 1'b0);
		pkt(CMD_FTP, 32'h0A00_0001, 16'd5000, 32'h0A00_0002, 16'h0, 1'b0, 1'b0, 3'd4, 1'b0);
		pkt(CMD_ACK, 32'h0A00_0002, FTP_DATA_PORT, 32'h0A00_0001, 16'd5000, 1'b1, 1'b0, 3'd6,
			1'b0);
		pkt(CMD_ACK, 32'h0A00_0001, 16'd5000, 32'h0A00_0002, FTP_DATA_PORT, 1'b0, 1'b1, 3'd3,
			1'b0);
		pkt(CMD_ACK, 32'h0A00_0002, FTP_DATA_PORT, 32'h0A00_0001, 16'd5000, 1'b0, 1'b1, 3'd3,
			1'b0);
		pkt(CMD_ACK, 32'h0A00_0001, 16'd5000, 32'h0A00_0002, FTP_DATA_PORT, 1'b0, 1'b0, 3'd3,
			1'b0);
		now = 32'hFFFF_FFF0;
		pkt(CMD_SYN, 32'h0A00_0003, 16'd1, 32'h0A00_0004, SMTP_PORT, 1'b1, 1'b0, 3'd0, 1'b0);
		pkt(CMD_ACK, 32'h0A00_0004, SMTP_PORT, 32'h0A00_0003, 16'd1, 1'b1, 1'b0, 3'd0, 1'b0);
		now = 32'd0;

		for (int ph = 0; ph < 8; ph++) begin
			set_timeout(timeouts[3'(ph)]);
			tx_mode = ph % 4;
			rx_mode = ph % 4;
			phase_start = tracker.accepted;
			if (ph == 2) begin
				// flood fresh tuples past the table size
				repeat (90) pkt(maybe(80) ? CMD_SYN : CMD_FTP, $urandom, 16'($urandom),
					$urandom, 16'($urandom), 1'b1, 1'b0, 3'($urandom), 1'($urandom));
			end
			if (ph == 5) begin
				tx_mode = 0;
				pressure_on = 1'b1;
				repeat (30) run_conn();
				tx_mode = 1;
			end
			while (tracker.accepted - phase_start < PHASE_ITEMS) begin
				case ($urandom_range(19))
					0, 1, 2: run_ftp();
					3, 4: noise();
					default: run_conn();
				endcase
			end
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.verdicts_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
